FILE: src/backing_store_map_table_defines.svh
// ----------------------------------------------------------------------------
// Backing-store map table assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef BACKING_STORE_MAP_TABLE_DEFINES_SVH
`define BACKING_STORE_MAP_TABLE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BSMT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BSMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bsmt_pkg.sv
// ----------------------------------------------------------------------------
// Backing-store map table package
// Field widths, command codes and offset limits shared by the block's files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsmt_pkg;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int EIDX_W = 3;
  localparam int PID_W  = 8;
  localparam int VA_W   = 32;
  localparam int BASE_W = 20;
  localparam int CNT_W  = 9;
  localparam int FIDX_W = 3;
  localparam int OFF_W  = 21;

  // Saturation limits of the signed page offset
  localparam logic signed [OFF_W-1:0] OFF_MAX = 21'sh0FFFFF;
  localparam logic signed [OFF_W-1:0] OFF_MIN = 21'sh100000;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_MAP    = 2'd3
  } cmd_t;

endpackage

FILE: src/bsmt_req_if.sv
// ----------------------------------------------------------------------------
// Backing-store map table command channel
// Valid/ready channel carrying one command per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsmt_req_if import bsmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [EIDX_W-1:0] entry_index;
  logic [PID_W-1:0]  process_id;
  logic [VA_W-1:0]   virtual_address;
  logic [BASE_W-1:0] base_page;
  logic [CNT_W-1:0]  page_count;

  modport source (
    output valid, cmd, entry_index, process_id, virtual_address, base_page, page_count,
    input  ready
  );

  modport sink (
    input  valid, cmd, entry_index, process_id, virtual_address, base_page, page_count,
    output ready
  );
endinterface

FILE: src/bsmt_rsp_if.sv
// ----------------------------------------------------------------------------
// Backing-store map table result channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsmt_rsp_if import bsmt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    ok;
  logic [FIDX_W-1:0]       found_index;
  logic signed [OFF_W-1:0] page_offset;

  modport source (
    output valid, ok, found_index, page_offset,
    input  ready
  );

  modport sink (
    input  valid, ok, found_index, page_offset,
    output ready
  );
endinterface

FILE: src/bsmt_pick.sv
// ----------------------------------------------------------------------------
// Backing-store map table priority pick
// Reports whether any candidate is set and the index of the lowest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsmt_pick #(
  parameter int N = 8
) (
  input  logic [N-1:0]         cand,
  output logic                 hit,
  output logic [$clog2(N)-1:0] index
);

  localparam int IDX_W = $clog2(N);

  logic [N-1:0] lowest;

  // Isolate the lowest set bit, then encode it
  assign lowest = cand & (~cand + N'(1));
  assign hit    = |cand;

  always_comb begin
    index = '0;
    for (int k = 0; k < N; k++) begin
      if (lowest[k]) begin
        index = index | IDX_W'(k);
      end
    end
  end

endmodule

FILE: src/backing_store_map_table.sv
// ----------------------------------------------------------------------------
// Backing-store map table
// ENTRIES-deep map of backing-store regions with allocate, free, lookup
// and map commands. Each gives one result; one is accepted per cycle
// unless both registers are full and the result stalls. The command is
// captured in an input register, all entries are compared in parallel
// with a priority pick, and the table and the result register update.
// The result register stalls independently, so a new command is taken
// while a finished result waits to be transferred. Commands act on the
// table strictly in order of acceptance. Lookup reports the lowest mapped
// entry owned by the process and the signed distance of the address page
// from that entry's base page, saturated to 21 bits. The page count of a
// map command is accepted but affects no answer. found_index carries the
// low three bits of the entry index; only entries 0 to 7 can be freed or
// mapped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module backing_store_map_table import bsmt_pkg::*; #(
  parameter int ENTRIES    = 8,
  parameter int PAGE_SHIFT = 12
) (
  input  logic       clk,
  input  logic       rst,
  bsmt_req_if.sink   req,
  bsmt_rsp_if.source rsp
);

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int PG_W    = VA_W - PAGE_SHIFT;
  localparam int DIFF_W  = ((PG_W > BASE_W) ? PG_W : BASE_W) + 1;
  localparam int IDX_X_W = IDX_W + FIDX_W;
  localparam logic signed [DIFF_W-1:0] SAT_HI = DIFF_W'(OFF_MAX);
  localparam logic signed [DIFF_W-1:0] SAT_LO = DIFF_W'(OFF_MIN);

  // Input register
  logic              s1_valid;
  cmd_t              s1_cmd;
  logic [EIDX_W-1:0] s1_idx;
  logic [PID_W-1:0]  s1_pid;
  logic [PG_W-1:0]   s1_page;
  logic [BASE_W-1:0] s1_base;

  // Table
  logic [ENTRIES-1:0] mapped;
  logic [PID_W-1:0]   owner    [ENTRIES];
  logic [BASE_W-1:0]  base_tab [ENTRIES];

  // Result register
  logic                    rsp_valid;
  logic                    rsp_ok;
  logic [FIDX_W-1:0]       rsp_found;
  logic signed [OFF_W-1:0] rsp_off;

  logic                    s1_go;
  logic [ENTRIES-1:0]      sel;
  logic [ENTRIES-1:0]      match;
  logic                    free_hit;
  logic [IDX_W-1:0]        free_idx;
  logic                    m_hit;
  logic [IDX_W-1:0]        m_idx;
  logic [IDX_X_W-1:0]      free_idx_x;
  logic [IDX_X_W-1:0]      m_idx_x;
  logic [BASE_W-1:0]       hit_base;
  logic signed [DIFF_W-1:0] diff;
  logic signed [OFF_W-1:0] off_sat;
  logic                    ok_next;
  logic [FIDX_W-1:0]       found_next;
  logic signed [OFF_W-1:0] off_next;

  // Handshake: the input register moves whenever the result register is free
  assign s1_go     = s1_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !s1_valid || !rsp_valid || rsp.ready;

  assign rsp.valid       = rsp_valid;
  assign rsp.ok          = rsp_ok;
  assign rsp.found_index = rsp_found;
  assign rsp.page_offset = rsp_off;

  // Capture the command
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1_cmd  <= cmd_t'(req.cmd);
      s1_idx  <= req.entry_index;
      s1_pid  <= req.process_id;
      s1_page <= req.virtual_address[VA_W-1:PAGE_SHIFT];
      s1_base <= req.base_page;
    end
  end

  // Per-entry select and owner compare
  for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
    assign sel[k]   = (32'(s1_idx) == k);
    assign match[k] = mapped[k] && (owner[k] == s1_pid);
  end

  bsmt_pick #(.N(ENTRIES)) u_free_pick (
    .cand  (~mapped),
    .hit   (free_hit),
    .index (free_idx)
  );

  bsmt_pick #(.N(ENTRIES)) u_match_pick (
    .cand  (match),
    .hit   (m_hit),
    .index (m_idx)
  );

  assign free_idx_x = IDX_X_W'(free_idx);
  assign m_idx_x    = IDX_X_W'(m_idx);

  // Page offset from the matched entry, saturated to the result width
  assign hit_base = base_tab[m_idx];
  assign diff     = $signed(DIFF_W'(s1_page) - DIFF_W'(hit_base));

  always_comb begin
    if (diff > SAT_HI) begin
      off_sat = OFF_MAX;
    end else if (diff < SAT_LO) begin
      off_sat = OFF_MIN;
    end else begin
      off_sat = diff[OFF_W-1:0];
    end
  end

  // Command decode
  always_comb begin
    ok_next    = 1'b0;
    found_next = '0;
    off_next   = '0;
    case (s1_cmd)
      CMD_ALLOC: begin
        ok_next    = free_hit;
        found_next = free_hit ? free_idx_x[FIDX_W-1:0] : '0;
      end
      CMD_FREE: begin
        ok_next = |(sel & mapped);
      end
      CMD_LOOKUP: begin
        ok_next    = m_hit;
        found_next = m_hit ? m_idx_x[FIDX_W-1:0] : '0;
        off_next   = m_hit ? off_sat : '0;
      end
      CMD_MAP: begin
        ok_next = |sel;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // Mapped flags; an unmapped entry's other fields are never read
  always_ff @(posedge clk) begin
    if (rst) begin
      mapped <= '0;
    end else if (s1_go) begin
      case (s1_cmd)
        CMD_FREE: mapped <= mapped & ~sel;
        CMD_MAP:  mapped <= mapped | sel;
        default:  mapped <= mapped;
      endcase
    end
  end

  // Owner and base page written by map
  always_ff @(posedge clk) begin
    for (int k = 0; k < ENTRIES; k++) begin
      if (s1_go && (s1_cmd == CMD_MAP) && sel[k]) begin
        owner[k]    <= s1_pid;
        base_tab[k] <= s1_base;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || rsp.ready) begin
      rsp_valid <= s1_valid;
    end
    if (s1_go) begin
      rsp_ok    <= ok_next;
      rsp_found <= found_next;
      rsp_off   <= off_next;
    end
  end

endmodule

FILE: src/bsmt_check.sv
// ----------------------------------------------------------------------------
// Backing-store map table port checker
// Watches the top-level channels for ordering and result-format slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "backing_store_map_table_defines.svh"

module bsmt_check import bsmt_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_valid,
  input logic                    req_ready,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic                    rsp_ok,
  input logic [FIDX_W-1:0]       rsp_found_index,
  input logic signed [OFF_W-1:0] rsp_page_offset
);

  // A stalled result holds
  `BSMT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ok) && $stable(rsp_found_index) && $stable(rsp_page_offset), "stalled result changed")

  // A failed command reports zero index and offset
  `BSMT_ASSERT_SAME(a_fail_zero, rsp_valid && !rsp_ok, rsp_found_index == '0 && rsp_page_offset == '0, "failed result carries data")

  // With no result pending the block takes commands
  `BSMT_ASSERT_SAME(a_ready_empty, !rsp_valid, req_ready, "command stalled with empty output")

  // A result appearing from idle comes from a command transfer through the input register
  `BSMT_ASSERT_SAME(a_rsp_origin, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without a command transfer")

endmodule

bind backing_store_map_table bsmt_check u_bsmt_check (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_ok          (rsp.ok),
  .rsp_found_index (rsp.found_index),
  .rsp_page_offset (rsp.page_offset)
);

FILE: tb/tb_backing_store_map_table.sv
// ----------------------------------------------------------------------------
// Backing-store map table testbench
// Runs directed and random allocate, free, lookup and map commands through
// the command channel, with random gaps and stalls on both sides and one
// long result stall. A local copy of the table predicts every answer, and
// each result transfer is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_backing_store_map_table;
  import bsmt_pkg::*;

  localparam int ENTRIES    = 8;
  localparam int PAGE_SHIFT = 12;
  localparam int RANDOM_CMDS = 550;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD = 60;

  typedef struct packed {
    cmd_t              cmd;
    logic [EIDX_W-1:0] entry_index;
    logic [PID_W-1:0]  process_id;
    logic [VA_W-1:0]   virtual_address;
    logic [BASE_W-1:0] base_page;
    logic [CNT_W-1:0]  page_count;
  } map_cmd_t;

  typedef struct packed {
    logic                    ok;
    logic [FIDX_W-1:0]       found_index;
    logic signed [OFF_W-1:0] page_offset;
  } map_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsmt_req_if req_ch ();
  bsmt_rsp_if rsp_ch ();

  backing_store_map_table #(
    .ENTRIES   (ENTRIES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table
  logic              tbl_mapped [ENTRIES];
  logic [PID_W-1:0]  tbl_owner  [ENTRIES];
  logic [BASE_W-1:0] tbl_base   [ENTRIES];
  logic [CNT_W-1:0]  tbl_pages  [ENTRIES];

  map_cmd_t    cmd_queue[$];
  map_answer_t pending_answers[$];

  // Generator pools: a few owners and bases so lookups mostly hit
  logic [PID_W-1:0]  pid_pool  [4];
  logic [BASE_W-1:0] base_pool [4];

  int errors = 0;
  int sent_count = 0;
  int total_cmds = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Apply one command to the shadow table and return its answer
  function automatic map_answer_t apply_command(map_cmd_t c);
    map_answer_t ans;
    int page_diff;
    int idx;
    ans = '0;
    idx = int'(c.entry_index);
    case (c.cmd)
      CMD_ALLOC: begin
        for (int k = 0; k < ENTRIES; k++) begin
          if (!ans.ok && !tbl_mapped[k]) begin
            ans.ok = 1'b1;
            ans.found_index = 3'(k);
          end
        end
      end
      CMD_FREE: begin
        if (idx < ENTRIES && tbl_mapped[idx]) begin
          tbl_mapped[idx] = 1'b0;
          tbl_owner[idx]  = '1;
          tbl_base[idx]   = 20'd4096;
          tbl_pages[idx]  = '0;
          ans.ok = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        for (int k = 0; k < ENTRIES; k++) begin
          if (!ans.ok && tbl_mapped[k] && tbl_owner[k] == c.process_id) begin
            page_diff = int'(c.virtual_address >> PAGE_SHIFT) - int'(tbl_base[k]);
            if (page_diff > int'(OFF_MAX)) page_diff = int'(OFF_MAX);
            if (page_diff < int'(OFF_MIN)) page_diff = int'(OFF_MIN);
            ans.ok = 1'b1;
            ans.found_index = 3'(k);
            ans.page_offset = page_diff[OFF_W-1:0];
          end
        end
      end
      default: begin
        if (idx < ENTRIES) begin
          tbl_mapped[idx] = 1'b1;
          tbl_owner[idx]  = c.process_id;
          tbl_base[idx]   = c.base_page;
          tbl_pages[idx]  = c.page_count;
          ans.ok = 1'b1;
        end
      end
    endcase
    return ans;
  endfunction

  function automatic void push_cmd(cmd_t op, int idx, int pid, logic [VA_W-1:0] va,
                                   int base, int cnt);
    map_cmd_t c;
    c.cmd = op;
    c.entry_index = EIDX_W'(idx);
    c.process_id = PID_W'(pid);
    c.virtual_address = va;
    c.base_page = BASE_W'(base);
    c.page_count = CNT_W'(cnt);
    cmd_queue.push_back(c);
  endfunction

  // Idle rates per phase: sender light / receiver heavy, swapped, then none
  function automatic int send_gap_pct();
    if (sent_count < total_cmds / 3) return 15;
    if (sent_count < 2 * total_cmds / 3) return 65;
    return 0;
  endfunction

  function automatic int recv_stall_pct();
    if (sent_count < total_cmds / 3) return 65;
    if (sent_count < 2 * total_cmds / 3) return 15;
    return 0;
  endfunction

  // Cycle counter for the run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Command driver: predict on each transfer, then offer the next command
  always @(posedge clk) begin
    map_cmd_t c;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        c.cmd = cmd_t'(req_ch.cmd);
        c.entry_index = req_ch.entry_index;
        c.process_id = req_ch.process_id;
        c.virtual_address = req_ch.virtual_address;
        c.base_page = req_ch.base_page;
        c.page_count = req_ch.page_count;
        pending_answers.push_back(apply_command(c));
        sent_count = sent_count + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= send_gap_pct()) begin
          c = cmd_queue.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.cmd <= c.cmd;
          req_ch.entry_index <= c.entry_index;
          req_ch.process_id <= c.process_id;
          req_ch.virtual_address <= c.virtual_address;
          req_ch.base_page <= c.base_page;
          req_ch.page_count <= c.page_count;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off in the no-idle phase, to back up the command side
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && total_cmds != 0 &&
                 sent_count >= 2 * total_cmds / 3 + 20) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: check each transfer, then pick the next ready
  always @(posedge clk) begin
    map_answer_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_answers.size() == 0) begin
          $error("unexpected result: ok %0d index %0d offset %0d",
                 rsp_ch.ok, rsp_ch.found_index, rsp_ch.page_offset);
          errors = errors + 1;
        end else begin
          want = pending_answers.pop_front();
          if (rsp_ch.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, rsp_ch.ok);
            errors = errors + 1;
          end
          if (rsp_ch.found_index !== want.found_index) begin
            $error("found_index: expected %0d, got %0d", want.found_index,
                   rsp_ch.found_index);
            errors = errors + 1;
          end
          if (rsp_ch.page_offset !== want.page_offset) begin
            $error("page_offset: expected %0d, got %0d", want.page_offset,
                   rsp_ch.page_offset);
            errors = errors + 1;
          end
        end
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct());
      end
    end
  end

  // Run limit
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Stimulus, reset and end of run
  initial begin
    map_cmd_t c;
    int r;
    int k;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_ALLOC;
    req_ch.entry_index = '0;
    req_ch.process_id = '0;
    req_ch.virtual_address = '0;
    req_ch.base_page = '0;
    req_ch.page_count = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_mapped[i] = 1'b0;
      tbl_owner[i]  = '1;
      tbl_base[i]   = 20'd4096;
      tbl_pages[i]  = '0;
    end
    for (int i = 0; i < 4; i++) begin
      pid_pool[i]  = PID_W'($urandom);
      base_pool[i] = BASE_W'($urandom);
    end

    // Directed: reset owner is all ones but nothing is mapped yet
    push_cmd(CMD_LOOKUP, 0, 255, 32'h0000_5000, 0, 0);
    push_cmd(CMD_ALLOC, 6, 0, 32'h0, 0, 0);
    // free of an unmapped entry
    push_cmd(CMD_FREE, 3, 0, 32'h0, 0, 0);
    // fill the table with extreme owners, bases and counts
    push_cmd(CMD_MAP, 0, 0,   32'h0, 20'h00000, 0);
    push_cmd(CMD_MAP, 1, 255, 32'h0, 20'hFFFFF, 256);
    push_cmd(CMD_MAP, 2, 8'h5A, 32'h0, 20'h12345, 1);
    push_cmd(CMD_MAP, 3, 7, 32'h0, 20'h55555, 170);
    push_cmd(CMD_MAP, 4, 7, 32'h0, 20'hAAAAA, 85);
    push_cmd(CMD_MAP, 5, 8'hA5, 32'h0, 20'h00001, 255);
    push_cmd(CMD_MAP, 6, 8'h80, 32'h0, 20'h80000, 128);
    push_cmd(CMD_MAP, 7, 8'h01, 32'h0, 20'h7FFFF, 2);
    // table full
    push_cmd(CMD_ALLOC, 0, 0, 32'h0, 0, 0);
    // largest positive and negative offsets
    push_cmd(CMD_LOOKUP, 0, 0, 32'hFFFF_FFFF, 0, 0);
    push_cmd(CMD_LOOKUP, 0, 255, 32'h0000_0FFF, 0, 0);
    // no owner match
    push_cmd(CMD_LOOKUP, 0, 8'hAA, 32'h1234_5678, 0, 0);
    // overwrite a mapped entry; lookup now picks the lower index
    push_cmd(CMD_MAP, 0, 8'h5A, 32'h0, 20'h12340, 3);
    push_cmd(CMD_LOOKUP, 0, 8'h5A, 32'h1234_5ABC, 0, 0);
    push_cmd(CMD_LOOKUP, 0, 7, 32'h5555_4000, 0, 0);
    push_cmd(CMD_FREE, 5, 0, 32'h0, 0, 0);
    push_cmd(CMD_ALLOC, 0, 0, 32'h0, 0, 0);
    push_cmd(CMD_FREE, 5, 0, 32'h0, 0, 0);
    push_cmd(CMD_LOOKUP, 0, 0, 32'h0000_1000, 0, 0);
    push_cmd(CMD_FREE, 7, 0, 32'h0, 0, 0);
    push_cmd(CMD_FREE, 0, 0, 32'h0, 0, 0);
    push_cmd(CMD_ALLOC, 0, 0, 32'h0, 0, 0);

    // Random: unused fields carry noise, owners and bases drawn mostly from pools
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      c.entry_index = EIDX_W'($urandom);
      c.process_id = PID_W'($urandom);
      c.virtual_address = $urandom;
      c.base_page = BASE_W'($urandom);
      c.page_count = CNT_W'($urandom_range(256));
      r = $urandom_range(99);
      k = $urandom_range(3);
      if (r < 32) begin
        c.cmd = CMD_MAP;
        if ($urandom_range(99) < 80) c.process_id = pid_pool[k];
        if ($urandom_range(1)) c.base_page = base_pool[$urandom_range(3)];
      end else if (r < 55) begin
        c.cmd = CMD_FREE;
      end else if (r < 85) begin
        c.cmd = CMD_LOOKUP;
        if ($urandom_range(99) < 85) c.process_id = pid_pool[k];
        if ($urandom_range(1)) begin
          c.virtual_address = {BASE_W'(base_pool[$urandom_range(3)]
                                       + BASE_W'($urandom_range(300))),
                               12'($urandom)};
        end
      end else begin
        c.cmd = CMD_ALLOC;
      end
      cmd_queue.push_back(c);
    end
    total_cmds = cmd_queue.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Drain: all commands taken and all answers seen
    @(negedge clk);
    while (cmd_queue.size() != 0 || req_ch.valid || pending_answers.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_answers.size() != 0) begin
      $error("%0d expected results never arrived", pending_answers.size());
      errors = errors + 1;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
